// ===== sv/smpq_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// smpq_pkg
// Types and constants shared by the slot priority queue modules.
// ============================================================================
package smpq_pkg;

    localparam int unsigned ID_W   = 16;
    localparam int unsigned PRIO_W = 8;
    localparam int unsigned CFG_W  = 4;
    localparam int unsigned WAIT_W = 4;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_POP    = 1'b1;

    // Search record handed from cell to cell
    typedef struct packed {
        logic              valid;
        logic              cmd;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
        logic              hit;
        logic [ID_W-1:0]   best_tag;
        logic [PRIO_W-1:0] best_prio;
    } carry_t;

    typedef struct packed {
        logic              ok;
        logic [ID_W-1:0]   out_id;
        logic [PRIO_W-1:0] out_priority;
        logic [WAIT_W-1:0] waiting;
    } result_t;

endpackage

// ===== sv/smpq_if.sv =====
`timescale 1ns / 1ps
// ============================================================================
// smpq_in_if / smpq_out_if
// Valid/ready channels carrying queue commands and queue results.
// ============================================================================
interface smpq_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [15:0] entry_id;
    logic [7:0]  entry_priority;

    modport source (output valid, cmd, entry_id, entry_priority, input ready);
    modport sink   (input valid, cmd, entry_id, entry_priority, output ready);
endinterface

interface smpq_out_if;
    logic        valid;
    logic        ready;
    logic        ok;
    logic [15:0] out_id;
    logic [7:0]  out_priority;
    logic [3:0]  waiting;

    modport source (output valid, ok, out_id, out_priority, waiting, input ready);
    modport sink   (input valid, ok, out_id, out_priority, waiting, output ready);
endinterface

// ===== sv/slot_min_priority_queue_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// slot_min_priority_queue_top
// Slot-based min priority queue with insert and pop commands.
// ============================================================================
// One item is in flight at a time. A command walks the row of SLOTS slot
// cells, one cell per cycle. The next item can be accepted only after the
// previous one leaves the row and the skid entry is empty, so no new item
// is taken while one is still in the row. A pop frees the chosen slot when
// the record leaves the last cell. A finished result waits in an output
// register (with one skid entry) while the next item is taken. slots_in_use
// sits at byte address 0.
module slot_min_priority_queue_top #(
    parameter int unsigned SLOTS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    smpq_in_if.sink     item_in,
    smpq_out_if.source  item_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int unsigned CNTW = $clog2(SLOTS + 1);
    localparam logic [1:0] ADDR_SLOTS_IN_USE = 2'd0;
    localparam logic [smpq_pkg::CFG_W-1:0] SLOTS_RESET = smpq_pkg::CFG_W'(8);

    logic [smpq_pkg::CFG_W-1:0] slots_in_use_reg;
    logic                       busy_reg;
    logic                       busy_next;
    smpq_pkg::carry_t           launch_reg;
    smpq_pkg::carry_t           launch_next;
    logic [CNTW-1:0]            count_reg;
    logic [CNTW-1:0]            count_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    smpq_pkg::result_t          out_reg;
    smpq_pkg::result_t          out_next;
    logic                       pend_valid_reg;
    logic                       pend_valid_next;
    smpq_pkg::result_t          pend_reg;
    smpq_pkg::result_t          pend_next;

    smpq_pkg::carry_t           chain [SLOTS+1];
    logic [IW-1:0]              chain_idx [SLOTS+1];

    smpq_pkg::carry_t           fin;
    smpq_pkg::result_t          res;
    logic                       in_acc;
    logic                       out_acc;
    logic                       clr;
    logic [CNTW+smpq_pkg::WAIT_W-1:0] count_wide;

    // Configuration port
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_SLOTS_IN_USE) ? 32'(slots_in_use_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_in_use_reg <= SLOTS_RESET;
        end
        else if (psel && penable && pwrite && (paddr == ADDR_SLOTS_IN_USE))
        begin
            slots_in_use_reg <= pwdata[smpq_pkg::CFG_W-1:0];
        end
    end

    // Cell row
    assign chain[0]     = launch_reg;
    assign chain_idx[0] = '0;

    genvar g;
    generate
        for (g = 0; g < SLOTS; g++)
        begin : g_cell
            smpq_cell #(
                .IDX (g),
                .IW  (IW)
            ) u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .slots_in_use (slots_in_use_reg),
                .carry_in     (chain[g]),
                .idx_in       (chain_idx[g]),
                .clr          (clr),
                .clr_idx      (chain_idx[SLOTS]),
                .carry_out    (chain[g+1]),
                .idx_out      (chain_idx[g+1])
            );
        end
    endgenerate

    assign fin     = chain[SLOTS];
    assign in_acc  = item_in.valid && item_in.ready;
    assign out_acc = out_valid_reg && item_out.ready;
    assign clr     = fin.valid && (fin.cmd == smpq_pkg::CMD_POP) && fin.hit;

    assign item_in.ready = !busy_reg && !pend_valid_reg;

    always_comb
    begin
        count_next = count_reg;
        if (fin.valid && fin.hit)
        begin
            if (fin.cmd == smpq_pkg::CMD_INSERT)
            begin
                count_next = count_reg + CNTW'(1);
            end
            else
            begin
                count_next = count_reg - CNTW'(1);
            end
        end
    end

    assign count_wide = (CNTW + smpq_pkg::WAIT_W)'(count_next);

    always_comb
    begin
        res.ok           = fin.hit;
        res.waiting      = count_wide[smpq_pkg::WAIT_W-1:0];
        res.out_id       = '0;
        res.out_priority = '0;
        if (fin.cmd == smpq_pkg::CMD_POP)
        begin
            res.out_id       = fin.best_tag;
            res.out_priority = fin.best_prio;
        end
    end

    always_comb
    begin
        launch_next           = '0;
        launch_next.valid     = in_acc;
        launch_next.cmd       = item_in.cmd;
        launch_next.id        = item_in.entry_id;
        launch_next.prio      = item_in.entry_priority;

        busy_next = busy_reg;
        if (in_acc)
        begin
            busy_next = 1'b1;
        end
        else if (fin.valid)
        begin
            busy_next = 1'b0;
        end

        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        if (out_acc)
        begin
            out_valid_next  = pend_valid_reg;
            out_next        = pend_reg;
            pend_valid_next = 1'b0;
        end
        if (fin.valid)
        begin
            if (!out_valid_reg || out_acc)
            begin
                out_valid_next = 1'b1;
                out_next       = res;
            end
            else
            begin
                pend_valid_next = 1'b1;
                pend_next       = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            launch_reg     <= '0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg       <= busy_next;
            launch_reg     <= launch_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        pend_reg <= pend_next;
    end

    assign item_out.valid        = out_valid_reg;
    assign item_out.ok           = out_reg.ok;
    assign item_out.out_id       = out_reg.out_id;
    assign item_out.out_priority = out_reg.out_priority;
    assign item_out.waiting      = out_reg.waiting;

    a_pend_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> out_valid_reg)
        else $error("skid entry held with empty output register");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= SLOTS)
        else $error("occupied count above slot count");

    a_fin_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        fin.valid |-> busy_reg)
        else $error("record left the row with no item in flight");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> busy_reg && launch_reg.valid)
        else $error("accepted item not launched");

endmodule

// ===== sv/smpq_cell.sv =====
`timescale 1ns / 1ps
// ============================================================================
// smpq_cell
// One queue slot: holds an entry and updates the passing search record.
// ============================================================================
module smpq_cell #(
    parameter int unsigned IDX = 0,
    parameter int unsigned IW  = 3
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [smpq_pkg::CFG_W-1:0]     slots_in_use,
    input  smpq_pkg::carry_t               carry_in,
    input  logic [IW-1:0]                  idx_in,
    input  logic                           clr,
    input  logic [IW-1:0]                  clr_idx,
    output smpq_pkg::carry_t               carry_out,
    output logic [IW-1:0]                  idx_out
);

    localparam int unsigned CW = 8;

    logic                          free_reg;
    logic                          free_next;
    logic [smpq_pkg::ID_W-1:0]     tag_reg;
    logic [smpq_pkg::PRIO_W-1:0]   prio_reg;
    smpq_pkg::carry_t              carry_reg;
    smpq_pkg::carry_t              carry_next;
    logic [IW-1:0]                 idx_reg;
    logic [IW-1:0]                 idx_next;
    logic                          usable;
    logic                          take;
    logic                          better;

    assign usable = CW'(slots_in_use) > CW'(IDX);
    assign take   = carry_in.valid && (carry_in.cmd == smpq_pkg::CMD_INSERT)
                    && !carry_in.hit && usable && free_reg;
    assign better = carry_in.valid && (carry_in.cmd == smpq_pkg::CMD_POP)
                    && usable && !free_reg
                    && (!carry_in.hit || (prio_reg < carry_in.best_prio));

    always_comb
    begin
        carry_next = carry_in;
        idx_next   = idx_in;
        free_next  = free_reg;
        if (take)
        begin
            carry_next.hit = 1'b1;
            free_next      = 1'b0;
        end
        if (better)
        begin
            carry_next.hit       = 1'b1;
            carry_next.best_tag  = tag_reg;
            carry_next.best_prio = prio_reg;
            idx_next             = IW'(IDX);
        end
        if (clr && (clr_idx == IW'(IDX)))
        begin
            free_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_reg  <= 1'b1;
            carry_reg <= '0;
        end
        else
        begin
            free_reg  <= free_next;
            carry_reg <= carry_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (take)
        begin
            tag_reg  <= carry_in.id;
            prio_reg <= carry_in.prio;
        end
    end

    assign carry_out = carry_reg;
    assign idx_out   = idx_reg;

endmodule

// ===== bench/slot_min_priority_queue_top_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// slot_min_priority_queue_top_tb
// Drives insert and pop commands into the slot priority queue under random
// source gaps and sink stalls, rewrites slots_in_use between drained phases,
// and checks every result against a cycle-free model of the slot row.
// ============================================================================
module slot_min_priority_queue_top_tb;

    localparam int SLOTS = 8;
    localparam logic [1:0] ADDR_SLOTS_IN_USE = 2'd0;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    smpq_in_if  in_ch ();
    smpq_out_if out_ch ();

    slot_min_priority_queue_top #(
        .SLOTS(SLOTS)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .item_in (in_ch),
        .item_out(out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    logic [smpq_pkg::ID_W-1:0]   slot_tag  [SLOTS];
    logic [smpq_pkg::PRIO_W-1:0] slot_prio [SLOTS];
    logic [SLOTS-1:0]            slot_busy;
    int                          busy_count;
    logic [smpq_pkg::CFG_W-1:0]  slots_limit;

    smpq_pkg::result_t pending_results[$];
    int      mismatches;
    int      burst_left;
    logic    in_active;
    int      phase_slots[12] = '{8, 1, 0, 15, 3, 8, 5, 2, 12, 6, 7, 4};

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic smpq_pkg::result_t queue_op(input logic cmd,
                                                   input logic [smpq_pkg::ID_W-1:0] id,
                                                   input logic [smpq_pkg::PRIO_W-1:0] prio);
        smpq_pkg::result_t r;
        int      lim;
        int      pick;
        r    = '0;
        lim  = (int'(slots_limit) > SLOTS) ? SLOTS : int'(slots_limit);
        pick = -1;
        if (cmd == smpq_pkg::CMD_INSERT)
        begin
            for (int i = 0; i < lim; i++)
                if (!slot_busy[i] && pick < 0)
                    pick = i;
            if (pick >= 0)
            begin
                slot_tag[pick]  = id;
                slot_prio[pick] = prio;
                slot_busy[pick] = 1'b1;
                busy_count++;
                r.ok = 1'b1;
            end
        end
        else
        begin
            for (int i = 0; i < lim; i++)
                if (slot_busy[i] && (pick < 0 || slot_prio[i] < slot_prio[pick]))
                    pick = i;
            if (pick >= 0)
            begin
                r.ok           = 1'b1;
                r.out_id       = slot_tag[pick];
                r.out_priority = slot_prio[pick];
                slot_busy[pick] = 1'b0;
                busy_count--;
            end
        end
        r.waiting = smpq_pkg::WAIT_W'(busy_count);
        return r;
    endfunction

    task automatic pace();
        int gap;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = $urandom_range(1, 24);
            in_ch.valid <= 1'b0;
            in_active = 1'b0;
            repeat (gap) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(0, 6);
        end
    endtask

    task automatic send_item(input logic cmd, input logic [smpq_pkg::ID_W-1:0] id,
                             input logic [smpq_pkg::PRIO_W-1:0] prio);
        in_ch.valid          <= 1'b1;
        in_ch.cmd            <= cmd;
        in_ch.entry_id       <= id;
        in_ch.entry_priority <= prio;
        in_active = 1'b1;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        pending_results.push_back(queue_op(cmd, id, prio));
        @(negedge clk);
        pace();
    endtask

    task automatic settle();
        if (in_active)
        begin
            in_ch.valid <= 1'b0;
            in_active = 1'b0;
        end
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SLOTS + 4) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_slots(input logic [smpq_pkg::CFG_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_SLOTS_IN_USE;
        pwdata  <= {28'($urandom()), value};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        slots_limit = value;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic test_fill_and_order();
        send_item(smpq_pkg::CMD_POP, 16'h1111, 8'h22);
        send_item(smpq_pkg::CMD_INSERT, 16'hFFFF, 8'hFF);
        send_item(smpq_pkg::CMD_INSERT, 16'h0000, 8'h00);
        send_item(smpq_pkg::CMD_INSERT, 16'hA5A5, 8'h7F);
        send_item(smpq_pkg::CMD_INSERT, 16'h5A5A, 8'h80);
        send_item(smpq_pkg::CMD_INSERT, 16'h1234, 8'h00);
        send_item(smpq_pkg::CMD_INSERT, 16'h8001, 8'hFF);
        send_item(smpq_pkg::CMD_INSERT, 16'h7FFE, 8'h01);
        send_item(smpq_pkg::CMD_INSERT, 16'h00FF, 8'hFE);
        send_item(smpq_pkg::CMD_INSERT, 16'hBEEF, 8'h10);
        send_item(smpq_pkg::CMD_POP, 16'hFFFF, 8'hFF);
        send_item(smpq_pkg::CMD_POP, 16'h0000, 8'h00);
        settle();
    endtask

    task automatic test_hidden_slots();
        set_slots(smpq_pkg::CFG_W'(2));
        send_item(smpq_pkg::CMD_POP, 16'h0000, 8'h00);
        send_item(smpq_pkg::CMD_POP, 16'h0000, 8'h00);
        send_item(smpq_pkg::CMD_INSERT, 16'hC0DE, 8'h33);
        send_item(smpq_pkg::CMD_INSERT, 16'h0F0F, 8'h33);
        send_item(smpq_pkg::CMD_INSERT, 16'hF0F0, 8'h00);
        settle();
    endtask

    task automatic test_zero_slots();
        set_slots(smpq_pkg::CFG_W'(0));
        send_item(smpq_pkg::CMD_INSERT, 16'h4321, 8'h05);
        send_item(smpq_pkg::CMD_POP, 16'h0000, 8'h00);
        settle();
    endtask

    task automatic test_saturated_limit();
        set_slots(smpq_pkg::CFG_W'(15));
        send_item(smpq_pkg::CMD_POP, 16'h0000, 8'h00);
        send_item(smpq_pkg::CMD_POP, 16'h0000, 8'h00);
        settle();
    endtask

    task automatic test_random_traffic();
        int   count;
        int   insert_pct;
        logic cmd;
        for (int p = 0; p < 12; p++)
        begin
            set_slots(smpq_pkg::CFG_W'(phase_slots[p]));
            count      = (phase_slots[p] == 0) ? 20 : 95;
            insert_pct = $urandom_range(30, 70);
            for (int n = 0; n < count; n++)
            begin
                cmd = ($urandom_range(0, 99) < insert_pct) ? smpq_pkg::CMD_INSERT
                                                           : smpq_pkg::CMD_POP;
                send_item(cmd, smpq_pkg::ID_W'($urandom()),
                          ($urandom_range(0, 3) == 0)
                              ? smpq_pkg::PRIO_W'($urandom_range(0, 3))
                              : smpq_pkg::PRIO_W'($urandom()));
            end
            settle();
        end
    endtask

    initial
    begin
        out_ch.ready <= 1'b0;
        forever
        begin
            int mode;
            int len;
            mode = $urandom_range(0, 3);
            len  = $urandom_range(5, 40);
            repeat (len)
            begin
                @(negedge clk);
                case (mode)
                    0: out_ch.ready <= 1'b1;
                    1: out_ch.ready <= ($urandom_range(0, 1) == 1);
                    2: out_ch.ready <= ($urandom_range(0, 9) == 0);
                    default: out_ch.ready <= ~out_ch.ready;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        smpq_pkg::result_t got;
        smpq_pkg::result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got.ok           = out_ch.ok;
            got.out_id       = out_ch.out_id;
            got.out_priority = out_ch.out_priority;
            got.waiting      = out_ch.waiting;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: ok=%0d id=%h prio=%h waiting=%0d",
                             got.ok, got.out_id, got.out_priority, got.waiting);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.ok !== want.ok || got.out_id !== want.out_id
                    || got.out_priority !== want.out_priority
                    || got.waiting !== want.waiting)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected ok=%0d id=%h prio=%h waiting=%0d,",
                                 want.ok, want.out_id, want.out_priority, want.waiting,
                                 " got ok=%0d id=%h prio=%h waiting=%0d",
                                 got.ok, got.out_id, got.out_priority, got.waiting);
                end
            end
        end
    end

    initial
    begin
        rst_n                = 1'b0;
        in_ch.valid          = 1'b0;
        in_ch.cmd            = smpq_pkg::CMD_INSERT;
        in_ch.entry_id       = '0;
        in_ch.entry_priority = '0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = ADDR_SLOTS_IN_USE;
        pwdata               = '0;
        slot_busy            = '0;
        busy_count           = 0;
        slots_limit          = smpq_pkg::CFG_W'(8);
        mismatches           = 0;
        burst_left           = 0;
        in_active            = 1'b0;
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_tag[i]  = '0;
            slot_prio[i] = '0;
        end
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (SLOTS + 4) @(negedge clk);

        test_fill_and_order();
        test_hidden_slots();
        test_zero_slots();
        test_saturated_limit();
        test_random_traffic();
        settle();

        if (mismatches == 0 && pending_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
